// ----- hw/rtl/plc3e_pkg.sv -----
// ----------------------------------------------------------------------------
// plc3e_pkg - shared types and constants of the 3E response frame parser
// Field widths, frame layout constants, register and status codes, and the
// hex field helpers used by the decoder.
// ----------------------------------------------------------------------------
package plc3e_pkg;

	// widths
	localparam int POS_W      = 17;
	localparam int WORD_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int NRES       = 3;
	localparam int CNT_W      = 2;

	// frame layout
	localparam int ASC_HDR_LEN = 18;
	localparam int ASC_EC_LEN  = 4;
	localparam int ASC_LEN_POS = 14;
	localparam int BIN_HDR_LEN = 9;
	localparam int BIN_EC_LEN  = 2;
	localparam int BIN_LEN_POS = 7;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [3:0] NIB_MASK = 4'h0F;
	localparam logic [WORD_W-1:0] END_CODE_OK = 16'h0000;

	// configuration register index
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ASCII_FORMAT = 2'd0,
		REG_EXPECT_DATA  = 2'd1,
		REG_BIT_MODE     = 2'd2,
		REG_BIT_COUNT    = 2'd3
	} cfg_reg_t;

	// frame status codes
	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_INVALID  = 2'd1,
		ST_END_CODE = 2'd2
	} status_t;

	typedef struct packed {
		logic              ascii_format;
		logic              expect_data;
		logic              bit_mode;
		logic [WORD_W-1:0] bit_count;
	} cfg_t;

	typedef struct packed {
		logic              is_status;
		logic [WORD_W-1:0] value;
		logic [1:0]        status;
		logic [WORD_W-1:0] end_code;
	} res_t;

	// results caused by one byte, in order, cnt of them valid
	typedef struct packed {
		logic [CNT_W-1:0]     cnt;
		res_t [NRES-1:0]      item;
	} res_set_t;

	typedef struct packed {
		logic [WORD_W-1:0] acc;
		logic              stop;
	} hex_t;

	// hex digit value, or 16 for a non-hex character
	function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
		logic [4:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = 5'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			d = 5'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			d = 5'(c - 8'h57);
		end else begin
			d = 5'd16;
		end
		return d;
	endfunction

	// one character of a leading-run hex field
	function automatic hex_t hex_take(input logic first, input logic [WORD_W-1:0] acc,
			input logic stop, input logic [BYTE_W-1:0] c);
		hex_t r;
		logic [4:0] d;
		d = hex_digit(c);
		r.acc = first ? '0 : acc;
		r.stop = first ? 1'b0 : stop;
		if (!r.stop && !d[4]) begin
			r.acc = {r.acc[WORD_W-5:0], d[3:0]};
		end else begin
			r.stop = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/plc3e_rx_if.sv -----
// ----------------------------------------------------------------------------
// plc3e_rx_if - received byte channel
// One frame byte or character per transaction, frame_end on the final one.
// ----------------------------------------------------------------------------
interface plc3e_rx_if;
	logic                      valid;
	logic                      ready;
	logic [plc3e_pkg::BYTE_W-1:0] data_byte;
	logic                      frame_end;

	modport source (output valid, data_byte, frame_end, input ready);
	modport sink (input valid, data_byte, frame_end, output ready);
endinterface

// ----- hw/rtl/plc3e_tx_if.sv -----
// ----------------------------------------------------------------------------
// plc3e_tx_if - result channel
// Data items and the closing status item of each frame.
// ----------------------------------------------------------------------------
interface plc3e_tx_if;
	logic                         valid;
	logic                         ready;
	logic                         is_status;
	logic [plc3e_pkg::WORD_W-1:0] value;
	logic [1:0]                   status;
	logic [plc3e_pkg::WORD_W-1:0] end_code;
	logic                         last;

	modport source (output valid, is_status, value, status, end_code, last, input ready);
	modport sink (input valid, is_status, value, status, end_code, last, output ready);
endinterface

// ----- hw/rtl/plc3e_cfg_if.sv -----
// ----------------------------------------------------------------------------
// plc3e_cfg_if - configuration write channel
// Register index and write data per transaction.
// ----------------------------------------------------------------------------
interface plc3e_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [plc3e_pkg::CFG_IDX_W-1:0]  index;
	logic [plc3e_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/plc_3e_response_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// plc_3e_response_frame_parser_unit - 3E response frame parser, top level
// Decodes ASCII or binary response frames byte by byte into data items and
// a closing status item per frame.
//
//   channel  dir  transaction carries
//   rx       in   data_byte, frame_end
//   tx       out  is_status, value, status, end_code, last
//   cfg      in   index, data (ascii_format, expect_data, bit_mode, bit_count)
//
// A byte passes the input register, then is decoded into the result buffer.
// The results of a byte leave one per result transaction: up to three in
// binary bit mode with frame end, limited by the single-item result port.
// Reset clears all frame state and sets the registers to binary, read
// response, word mode, bit_count 1.
// tx stalls hold the result buffer and, once the input register is full, rx.
// ----------------------------------------------------------------------------
module plc_3e_response_frame_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	plc3e_rx_if.sink   rx,
	plc3e_tx_if.source tx,
	plc3e_cfg_if.sink  cfg
);

	plc3e_pkg::cfg_t     cfg_regs;
	plc3e_pkg::res_set_t res_set;
	logic                res_load;
	logic                res_free;

	plc3e_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	plc3e_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg_regs (cfg_regs),
		.res_free (res_free),
		.res_load (res_load),
		.res_set  (res_set)
	);

	plc3e_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_load (res_load),
		.res_set  (res_set),
		.res_free (res_free),
		.tx       (tx)
	);

endmodule

// ----- hw/rtl/plc3e_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// plc3e_cfg_regs - configuration registers
// Takes a write on every transaction of the configuration channel.
// ----------------------------------------------------------------------------
module plc3e_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	plc3e_cfg_if.sink         cfg,
	output plc3e_pkg::cfg_t   cfg_regs
);

	plc3e_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs = regs_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.ascii_format <= 1'b0;
			regs_q.expect_data  <= 1'b1;
			regs_q.bit_mode     <= 1'b0;
			regs_q.bit_count    <= plc3e_pkg::WORD_W'(1);
		end else if (cfg.valid) begin
			case (plc3e_pkg::cfg_reg_t'(cfg.index))
				plc3e_pkg::REG_ASCII_FORMAT: regs_q.ascii_format <= cfg.data[0];
				plc3e_pkg::REG_EXPECT_DATA:  regs_q.expect_data  <= cfg.data[0];
				plc3e_pkg::REG_BIT_MODE:     regs_q.bit_mode     <= cfg.data[0];
				plc3e_pkg::REG_BIT_COUNT:    regs_q.bit_count    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/plc3e_decode.sv -----
// ----------------------------------------------------------------------------
// plc3e_decode - input register, frame state and byte decoder
// Registers each received byte, decodes it against the frame state and hands
// the results it causes (up to three) to the result buffer in one step.
// ----------------------------------------------------------------------------
module plc3e_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	plc3e_rx_if.sink             rx,
	input  plc3e_pkg::cfg_t      cfg_regs,
	input  logic                 res_free,
	output logic                 res_load,
	output plc3e_pkg::res_set_t  res_set
);

	localparam int PW = plc3e_pkg::POS_W;
	localparam int WW = plc3e_pkg::WORD_W;

	// input register
	logic                           valid_s1;
	logic [plc3e_pkg::BYTE_W-1:0]   byte_s1;
	logic                           fe_s1;

	// frame state
	logic [PW-1:0]  pos_q;
	logic [WW-1:0]  len_q;
	logic [WW-1:0]  ec_q;
	logic [WW-1:0]  hacc_q;
	logic           hstop_q;
	logic [1:0]     phase_q;
	logic [7:0]     lowb_q;
	logic [WW-1:0]  bits_q;
	logic           derr_q;

	// next state
	logic [PW-1:0]  pos_d;
	logic [WW-1:0]  len_d;
	logic [WW-1:0]  ec_d;
	logic [WW-1:0]  hacc_d;
	logic           hstop_d;
	logic [1:0]     phase_d;
	logic [7:0]     lowb_d;
	logic [WW-1:0]  bits_d;
	logic           derr_d;

	logic              adv;
	logic              hfirst;
	plc3e_pkg::hex_t   hx;
	logic              d0_v, d1_v;
	logic [WW-1:0]     d0, d1;
	logic [3:0]        nib_hi, nib_lo;
	logic              take_hi, take_lo;
	logic [WW-1:0]     bits_mid;
	logic [PW:0]       total;
	logic [PW:0]       hdr;
	logic [PW:0]       ecs;
	logic [1:0]        st;
	plc3e_pkg::res_t   st_item;
	plc3e_pkg::res_t   d0_item, d1_item;
	logic [1:0]        ndata;

	assign adv = valid_s1 && res_free;
	assign rx.ready = !valid_s1 || adv;
	assign res_load = adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			fe_s1   <= rx.frame_end;
		end
	end

	// hex field character, shared by length, end code and ASCII words
	always_comb begin
		hfirst = (pos_q == PW'(plc3e_pkg::ASC_LEN_POS))
			|| (pos_q == PW'(plc3e_pkg::ASC_HDR_LEN))
			|| (pos_q >= PW'(plc3e_pkg::ASC_HDR_LEN + plc3e_pkg::ASC_EC_LEN)
				&& phase_q == 2'd0);
		hx = plc3e_pkg::hex_take(hfirst, hacc_q, hstop_q, byte_s1);
	end

	// byte decode
	always_comb begin
		len_d   = len_q;
		ec_d    = ec_q;
		hacc_d  = hacc_q;
		hstop_d = hstop_q;
		phase_d = phase_q;
		lowb_d  = lowb_q;
		bits_d  = bits_q;
		derr_d  = derr_q;
		d0_v    = 1'b0;
		d1_v    = 1'b0;
		d0      = '0;
		d1      = '0;
		nib_hi  = byte_s1[7:4];
		nib_lo  = byte_s1[3:0] & plc3e_pkg::NIB_MASK;
		take_hi = bits_q < cfg_regs.bit_count;
		bits_mid = bits_q + WW'(take_hi);
		take_lo = bits_mid < cfg_regs.bit_count;
		if (cfg_regs.ascii_format) begin
			if (pos_q >= PW'(plc3e_pkg::ASC_LEN_POS)
					&& pos_q < PW'(plc3e_pkg::ASC_HDR_LEN)) begin
				hacc_d  = hx.acc;
				hstop_d = hx.stop;
				if (pos_q == PW'(plc3e_pkg::ASC_HDR_LEN - 1)) begin
					len_d = hx.acc;
				end
			end else if (pos_q >= PW'(plc3e_pkg::ASC_HDR_LEN)
					&& pos_q < PW'(plc3e_pkg::ASC_HDR_LEN + plc3e_pkg::ASC_EC_LEN)) begin
				hacc_d  = hx.acc;
				hstop_d = hx.stop;
				ec_d    = hx.acc;
			end else if (pos_q >= PW'(plc3e_pkg::ASC_HDR_LEN + plc3e_pkg::ASC_EC_LEN)
					&& cfg_regs.expect_data) begin
				if (cfg_regs.bit_mode) begin
					if (byte_s1 == 8'h30 || byte_s1 == 8'h31) begin
						d0_v = 1'b1;
						d0   = WW'(byte_s1[0]);
					end else begin
						derr_d = 1'b1;
					end
				end else begin
					hacc_d  = hx.acc;
					hstop_d = hx.stop;
					if (phase_q == 2'd3) begin
						d0_v    = 1'b1;
						d0      = hx.acc;
						phase_d = 2'd0;
					end else begin
						phase_d = phase_q + 2'd1;
					end
				end
			end
		end else begin
			if (pos_q == PW'(plc3e_pkg::BIN_LEN_POS)) begin
				len_d[7:0] = byte_s1;
			end else if (pos_q == PW'(plc3e_pkg::BIN_LEN_POS + 1)) begin
				len_d[15:8] = byte_s1;
			end else if (pos_q == PW'(plc3e_pkg::BIN_HDR_LEN)) begin
				ec_d[7:0] = byte_s1;
			end else if (pos_q == PW'(plc3e_pkg::BIN_HDR_LEN + 1)) begin
				ec_d[15:8] = byte_s1;
			end else if (pos_q >= PW'(plc3e_pkg::BIN_HDR_LEN + plc3e_pkg::BIN_EC_LEN)
					&& cfg_regs.expect_data) begin
				if (cfg_regs.bit_mode) begin
					// high nibble first, each counted while below bit_count
					if (take_hi) begin
						if (nib_hi > 4'd1) begin
							derr_d = 1'b1;
						end else begin
							d0_v = 1'b1;
							d0   = WW'(nib_hi[0]);
						end
					end
					if (take_lo) begin
						if (nib_lo > 4'd1) begin
							derr_d = 1'b1;
						end else if (d0_v) begin
							d1_v = 1'b1;
							d1   = WW'(nib_lo[0]);
						end else begin
							d0_v = 1'b1;
							d0   = WW'(nib_lo[0]);
						end
					end
					bits_d = bits_mid + WW'(take_lo);
				end else if (phase_q == 2'd0) begin
					lowb_d  = byte_s1;
					phase_d = 2'd1;
				end else begin
					d0_v    = 1'b1;
					d0      = {byte_s1, lowb_q};
					phase_d = 2'd0;
				end
			end
		end
		pos_d = (pos_q == plc3e_pkg::POS_MAX) ? pos_q : pos_q + PW'(1);
	end

	// frame status on the final byte
	always_comb begin
		total = {1'b0, pos_q} + (PW+1)'(1);
		hdr = cfg_regs.ascii_format ? (PW+1)'(plc3e_pkg::ASC_HDR_LEN)
			: (PW+1)'(plc3e_pkg::BIN_HDR_LEN);
		ecs = cfg_regs.ascii_format ? (PW+1)'(plc3e_pkg::ASC_EC_LEN)
			: (PW+1)'(plc3e_pkg::BIN_EC_LEN);
		if (total < hdr + ecs) begin
			st = plc3e_pkg::ST_INVALID;
		end else if (len_d == '0 || {{(PW+1-WW){1'b0}}, len_d} != total - hdr) begin
			st = plc3e_pkg::ST_INVALID;
		end else if (ec_d != plc3e_pkg::END_CODE_OK) begin
			st = plc3e_pkg::ST_END_CODE;
		end else if (cfg_regs.expect_data && derr_d) begin
			st = plc3e_pkg::ST_INVALID;
		end else if (cfg_regs.expect_data && !cfg_regs.bit_mode && phase_d != 2'd0) begin
			st = plc3e_pkg::ST_INVALID;
		end else begin
			st = plc3e_pkg::ST_GOOD;
		end
	end

	// result set, data items first and the status item after them
	always_comb begin
		st_item.is_status = 1'b1;
		st_item.value     = '0;
		st_item.status    = st;
		st_item.end_code  = ec_d;
		d0_item.is_status = 1'b0;
		d0_item.value     = d0;
		d0_item.status    = plc3e_pkg::ST_GOOD;
		d0_item.end_code  = '0;
		d1_item.is_status = 1'b0;
		d1_item.value     = d1;
		d1_item.status    = plc3e_pkg::ST_GOOD;
		d1_item.end_code  = '0;
		ndata = 2'(d0_v) + 2'(d1_v);
		res_set.item[0] = d0_v ? d0_item : st_item;
		res_set.item[1] = d1_v ? d1_item : st_item;
		res_set.item[2] = st_item;
		res_set.cnt = ndata + 2'(fe_s1);
	end

	// frame state update, cleared when the frame end byte is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			len_q   <= '0;
			ec_q    <= '0;
			hacc_q  <= '0;
			hstop_q <= 1'b0;
			phase_q <= '0;
			lowb_q  <= '0;
			bits_q  <= '0;
			derr_q  <= 1'b0;
		end else if (adv) begin
			if (fe_s1) begin
				pos_q   <= '0;
				len_q   <= '0;
				ec_q    <= '0;
				hacc_q  <= '0;
				hstop_q <= 1'b0;
				phase_q <= '0;
				lowb_q  <= '0;
				bits_q  <= '0;
				derr_q  <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				len_q   <= len_d;
				ec_q    <= ec_d;
				hacc_q  <= hacc_d;
				hstop_q <= hstop_d;
				phase_q <= phase_d;
				lowb_q  <= lowb_d;
				bits_q  <= bits_d;
				derr_q  <= derr_d;
			end
		end
	end

	// a frame end always restarts the byte count
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && fe_s1 |=> pos_q == '0)
		else $error("byte position not cleared after frame end");

	// byte count steps by one until it saturates
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !fe_s1 && pos_q != plc3e_pkg::POS_MAX |=> pos_q == $past(pos_q) + PW'(1))
		else $error("byte position did not advance");

	// a byte waiting for the result buffer stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input register dropped a waiting byte");

endmodule

// ----- hw/rtl/plc3e_out_buf.sv -----
// ----------------------------------------------------------------------------
// plc3e_out_buf - result buffer
// Holds the result set of one byte and drives it out one item per
// transaction, marking the final one.
// ----------------------------------------------------------------------------
module plc3e_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_load,
	input  plc3e_pkg::res_set_t  res_set,
	output logic                 res_free,
	plc3e_tx_if.source           tx
);

	plc3e_pkg::res_t [plc3e_pkg::NRES-1:0] item_q;
	logic [plc3e_pkg::CNT_W-1:0]           cnt_q;
	logic [plc3e_pkg::CNT_W-1:0]           rd_q;
	logic                                  at_last;
	plc3e_pkg::res_t                       cur;

	assign tx.valid = rd_q < cnt_q;
	assign at_last  = rd_q == cnt_q - plc3e_pkg::CNT_W'(1);
	assign res_free = !tx.valid || (tx.ready && at_last);

	// output view of the current item
	always_comb begin
		cur = item_q[rd_q];
		tx.is_status = cur.is_status;
		tx.value     = cur.value;
		tx.status    = cur.status;
		tx.end_code  = cur.end_code;
		tx.last      = at_last;
	end

	// read pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (res_load) begin
			cnt_q <= res_set.cnt;
			rd_q  <= '0;
		end else if (tx.valid && tx.ready) begin
			rd_q <= rd_q + plc3e_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			item_q <= res_set.item;
		end
	end

	// never overwrite a set that still has items to deliver
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_free)
		else $error("result set loaded over undelivered items");

	// read pointer stays within the set
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q && cnt_q <= plc3e_pkg::CNT_W'(plc3e_pkg::NRES))
		else $error("result read pointer out of range");

	// a stalled result transaction holds its item
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.ready |=> tx.valid && $stable(rd_q) && $stable(cur))
		else $error("result changed while stalled");

endmodule

// ----- verif/plc3e_frame_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plc3e_frame_checker - result checker for the 3E response frame parser
// Watches the byte, result and register channels, decodes each accepted byte
// with its own copy of the register and frame state, and compares every
// result transaction field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module plc3e_frame_checker (
	input  logic clk,
	input  logic arst_n,
	plc3e_rx_if  rx,
	plc3e_tx_if  tx,
	plc3e_cfg_if cfg,
	output int   fail_count,
	output int   pending_results
);

	typedef struct packed {
		plc3e_pkg::res_t item;
		logic            last;
	} frame_result_t;

	// register mirror
	logic                         ascii_fmt;
	logic                         read_resp;
	logic                         bit_pts;
	logic [plc3e_pkg::WORD_W-1:0] n_bits;

	// frame decode state
	logic [plc3e_pkg::POS_W-1:0]  pos;
	logic [plc3e_pkg::WORD_W-1:0] len_field;
	logic [plc3e_pkg::WORD_W-1:0] ec_field;
	logic [plc3e_pkg::WORD_W-1:0] hex_acc;
	logic                         hex_done;
	logic [1:0]                   grp;
	logic [plc3e_pkg::BYTE_W-1:0] lo_hold;
	logic [plc3e_pkg::WORD_W-1:0] bits_taken;
	logic                         bad_data;

	frame_result_t expected_results[$];
	frame_result_t oldest;
	int            new_count;
	int            errors;

	// value of a hex character, -1 for anything else
	function automatic int hex_value(input logic [plc3e_pkg::BYTE_W-1:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
		return -1;
	endfunction

	// leading-run hex field: the first non-hex character freezes the value
	task automatic hex_feed(input logic first, input logic [plc3e_pkg::BYTE_W-1:0] c);
		int d;
		d = hex_value(c);
		if (first) begin
			hex_acc = '0;
			hex_done = 1'b0;
		end
		if (!hex_done && d >= 0) begin
			hex_acc = {hex_acc[plc3e_pkg::WORD_W-5:0], 4'(d)};
		end else begin
			hex_done = 1'b1;
		end
	endtask

	task automatic clear_frame_state();
		pos = '0;
		len_field = '0;
		ec_field = '0;
		hex_acc = '0;
		hex_done = 1'b0;
		grp = '0;
		lo_hold = '0;
		bits_taken = '0;
		bad_data = 1'b0;
	endtask

	task automatic push_result(input logic is_st, input logic [plc3e_pkg::WORD_W-1:0] val,
			input plc3e_pkg::status_t st, input logic [plc3e_pkg::WORD_W-1:0] code);
		frame_result_t r;
		r.item.is_status = is_st;
		r.item.value = val;
		r.item.status = st;
		r.item.end_code = code;
		r.last = 1'b0;
		expected_results.push_back(r);
		new_count++;
	endtask

	// decode one byte of the frame and queue the results it causes
	task automatic decode_byte(input logic [plc3e_pkg::BYTE_W-1:0] b, input logic fe);
		logic [plc3e_pkg::POS_W-1:0] idx;
		logic [3:0]                  nib;
		int unsigned                 total;
		int unsigned                 hdr;
		int unsigned                 ecl;
		plc3e_pkg::status_t          st;
		frame_result_t               r;
		idx = pos;
		new_count = 0;
		if (ascii_fmt) begin
			if (idx >= plc3e_pkg::ASC_LEN_POS && idx < plc3e_pkg::ASC_LEN_POS + 4) begin
				hex_feed(idx == plc3e_pkg::ASC_LEN_POS, b);
				if (idx == plc3e_pkg::ASC_LEN_POS + 3)
					len_field = hex_acc;
			end else if (idx >= plc3e_pkg::ASC_HDR_LEN
					&& idx < plc3e_pkg::ASC_HDR_LEN + plc3e_pkg::ASC_EC_LEN) begin
				hex_feed(idx == plc3e_pkg::ASC_HDR_LEN, b);
				ec_field = hex_acc;
			end else if (idx >= plc3e_pkg::ASC_HDR_LEN + plc3e_pkg::ASC_EC_LEN
					&& read_resp) begin
				if (bit_pts) begin
					// only the characters '0' and '1' are bit points
					if (b == 8'h30)
						push_result(1'b0, 16'd0, plc3e_pkg::ST_GOOD, '0);
					else if (b == 8'h31)
						push_result(1'b0, 16'd1, plc3e_pkg::ST_GOOD, '0);
					else
						bad_data = 1'b1;
				end else begin
					hex_feed(grp == 2'd0, b);
					if (grp == 2'd3) begin
						push_result(1'b0, hex_acc, plc3e_pkg::ST_GOOD, '0);
						grp = 2'd0;
					end else begin
						grp++;
					end
				end
			end
		end else begin
			if (idx == plc3e_pkg::BIN_LEN_POS) begin
				len_field[7:0] = b;
			end else if (idx == plc3e_pkg::BIN_LEN_POS + 1) begin
				len_field[15:8] = b;
			end else if (idx == plc3e_pkg::BIN_HDR_LEN) begin
				ec_field[7:0] = b;
			end else if (idx == plc3e_pkg::BIN_HDR_LEN + 1) begin
				ec_field[15:8] = b;
			end else if (idx >= plc3e_pkg::BIN_HDR_LEN + plc3e_pkg::BIN_EC_LEN
					&& read_resp) begin
				if (bit_pts) begin
					// high nibble first; nibbles past bit_count are dropped unchecked
					for (int k = 0; k < 2; k++) begin
						nib = (k == 0) ? b[7:4] : b[3:0];
						if (bits_taken < n_bits) begin
							if (nib > 4'd1)
								bad_data = 1'b1;
							else
								push_result(1'b0, 16'(nib), plc3e_pkg::ST_GOOD, '0);
							bits_taken++;
						end
					end
				end else if (grp == 2'd0) begin
					lo_hold = b;
					grp = 2'd1;
				end else begin
					push_result(1'b0, {b, lo_hold}, plc3e_pkg::ST_GOOD, '0);
					grp = 2'd0;
				end
			end
		end

		if (pos != plc3e_pkg::POS_MAX)
			pos++;

		// closing status, in priority order
		if (fe) begin
			total = int'(idx) + 1;
			hdr = ascii_fmt ? plc3e_pkg::ASC_HDR_LEN : plc3e_pkg::BIN_HDR_LEN;
			ecl = ascii_fmt ? plc3e_pkg::ASC_EC_LEN : plc3e_pkg::BIN_EC_LEN;
			st = plc3e_pkg::ST_GOOD;
			if (total < hdr + ecl)
				st = plc3e_pkg::ST_INVALID;
			else if (len_field == 0 || int'(len_field) != total - hdr)
				st = plc3e_pkg::ST_INVALID;
			else if (ec_field != plc3e_pkg::END_CODE_OK)
				st = plc3e_pkg::ST_END_CODE;
			else if (read_resp && bad_data)
				st = plc3e_pkg::ST_INVALID;
			else if (read_resp && !bit_pts && grp != 2'd0)
				st = plc3e_pkg::ST_INVALID;
			push_result(1'b1, '0, st, ec_field);
			clear_frame_state();
		end

		if (new_count > 0) begin
			r = expected_results.pop_back();
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ascii_fmt = 1'b0;
			read_resp = 1'b1;
			bit_pts = 1'b0;
			n_bits = 16'd1;
			clear_frame_state();
			expected_results.delete();
			errors = 0;
			fail_count <= 0;
			pending_results <= 0;
		end else begin
			// result transaction against the oldest prediction
			if (tx.valid && tx.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result is_status=%0b value=%h status=%0d end_code=%h last=%0b",
						$time, tx.is_status, tx.value, tx.status, tx.end_code, tx.last);
				end else begin
					oldest = expected_results.pop_front();
					if (tx.is_status !== oldest.item.is_status || tx.value !== oldest.item.value ||
							tx.status !== oldest.item.status ||
							tx.end_code !== oldest.item.end_code || tx.last !== oldest.last) begin
						errors++;
						$display("%0t: result mismatch, expected is_status=%0b value=%h status=%0d end_code=%h last=%0b",
							$time, oldest.item.is_status, oldest.item.value,
							oldest.item.status, oldest.item.end_code, oldest.last);
						$display("%0t: result mismatch, actual   is_status=%0b value=%h status=%0d end_code=%h last=%0b",
							$time, tx.is_status, tx.value, tx.status, tx.end_code, tx.last);
					end
				end
			end

			// register write
			if (cfg.valid && cfg.ready) begin
				case (plc3e_pkg::cfg_reg_t'(cfg.index))
					plc3e_pkg::REG_ASCII_FORMAT: ascii_fmt = cfg.data[0];
					plc3e_pkg::REG_EXPECT_DATA:  read_resp = cfg.data[0];
					plc3e_pkg::REG_BIT_MODE:     bit_pts = cfg.data[0];
					plc3e_pkg::REG_BIT_COUNT:    n_bits = cfg.data;
					default: ;
				endcase
			end

			// byte transaction
			if (rx.valid && rx.ready)
				decode_byte(rx.data_byte, rx.frame_end);

			fail_count <= errors;
			pending_results <= expected_results.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the 3E response frame parser
// Sends random response frames in random register settings, starting from
// the reset setting, with random gaps on the byte side and random stalls on
// the result side. Checking is done by the frame checker beside the block;
// this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	typedef enum int {
		FK_GOOD,
		FK_BAD_LEN,
		FK_END_CODE,
		FK_BAD_DATA,
		FK_SHORT,
		FK_NOISE
	} frame_kind_t;

	localparam int ITEM_TARGET = 110;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   fail_count;
	int   pending_results;
	int   sent_items;
	int   frame_no;

	// register values as last written
	logic                         ascii_mode;
	logic                         read_resp;
	logic                         bit_pts;
	logic [plc3e_pkg::WORD_W-1:0] n_bits;

	logic [plc3e_pkg::BYTE_W-1:0] frame_bytes[$];
	frame_kind_t                  kind;
	int                           pick;

	plc3e_rx_if  rx_ch();
	plc3e_tx_if  tx_ch();
	plc3e_cfg_if cfg_ch();

	plc_3e_response_frame_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch),
		.cfg    (cfg_ch)
	);

	plc3e_frame_checker frame_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx_ch),
		.tx              (tx_ch),
		.cfg             (cfg_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure
	initial tx_ch.ready = 1'b0;
	always @(posedge clk)
		tx_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic upper;
		upper = 1'($urandom_range(1));
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex_char();
		case ($urandom_range(3))
			0:       return 8'($urandom_range(8'h00, 8'h2F));
			1:       return 8'($urandom_range(8'h3A, 8'h40));
			2:       return 8'($urandom_range(8'h47, 8'h60));
			default: return 8'($urandom_range(8'h67, 8'hFF));
		endcase
	endfunction

	// one byte transaction, with a random gap in front
	task automatic send_byte(input logic [7:0] b, input logic fe);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.data_byte <= b;
		rx_ch.frame_end <= fe;
		do @(posedge clk); while (rx_ch.ready !== 1'b1);
		sent_items++;
	endtask

	// wait until every predicted result has come out
	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(input logic asc, input logic rd, input logic bp,
			input logic [15:0] nb);
		settle();
		ascii_mode = asc;
		read_resp = rd;
		bit_pts = bp;
		n_bits = nb;
		for (int k = 0; k < 4; k++) begin
			cfg_ch.valid <= 1'b1;
			case (k)
				0: begin
					cfg_ch.index <= plc3e_pkg::REG_ASCII_FORMAT;
					cfg_ch.data <= 16'(asc);
				end
				1: begin
					cfg_ch.index <= plc3e_pkg::REG_EXPECT_DATA;
					cfg_ch.data <= 16'(rd);
				end
				2: begin
					cfg_ch.index <= plc3e_pkg::REG_BIT_MODE;
					cfg_ch.data <= 16'(bp);
				end
				default: begin
					cfg_ch.index <= plc3e_pkg::REG_BIT_COUNT;
					cfg_ch.data <= nb;
				end
			endcase
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// frame for the current register setting; extreme gives all-zero/all-one words
	task automatic build_frame(input frame_kind_t fk, input bit extreme);
		logic [7:0]  body[$];
		logic [3:0]  nibs[$];
		logic [15:0] len;
		logic [15:0] ec;
		int          n;
		int          taken;
		int          hdr;
		int          ecl;
		frame_bytes.delete();
		if (fk == FK_NOISE) begin
			n = $urandom_range(1, 40);
			repeat (n) frame_bytes.push_back(8'($urandom));
			return;
		end
		ec = (fk == FK_END_CODE) ? 16'($urandom_range(1, 16'hFFFF))
			: plc3e_pkg::END_CODE_OK;

		// payload
		if (!read_resp) begin
			repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
		end else if (ascii_mode && bit_pts) begin
			n = $urandom_range(1, 12);
			repeat (n) body.push_back($urandom_range(1) ? 8'h31 : 8'h30);
			if (fk == FK_BAD_DATA)
				body[$urandom_range(n - 1)] = $urandom_range(1) ? non_hex_char()
					: hex_char(4'($urandom_range(2, 15)));
		end else if (ascii_mode) begin
			n = extreme ? 8 : 4 * $urandom_range(0, 4);
			for (int k = 0; k < n; k++) begin
				if (extreme)
					body.push_back(hex_char(k < 4 ? 4'h0 : 4'hF));
				else if ($urandom_range(7) == 0)
					body.push_back(non_hex_char());
				else
					body.push_back(hex_char(4'($urandom)));
			end
			// partial word at the end
			if (fk == FK_BAD_DATA)
				repeat ($urandom_range(1, 3)) body.push_back(hex_char(4'($urandom)));
		end else if (bit_pts) begin
			n = $urandom_range(1, 12);
			taken = (2 * n < int'(n_bits)) ? 2 * n : int'(n_bits);
			for (int k = 0; k < 2 * n; k++)
				nibs.push_back(k < taken ? 4'($urandom_range(1)) : 4'($urandom));
			if (fk == FK_BAD_DATA)
				nibs[$urandom_range(taken - 1)] = 4'($urandom_range(2, 15));
			for (int k = 0; k < n; k++)
				body.push_back({nibs[2 * k], nibs[2 * k + 1]});
		end else begin
			n = extreme ? 2 : $urandom_range(0, 6);
			for (int k = 0; k < 2 * n; k++)
				body.push_back(extreme ? (k < 2 ? 8'h00 : 8'hFF) : 8'($urandom));
			if (fk == FK_BAD_DATA)
				body.push_back(8'($urandom));
		end

		hdr = ascii_mode ? plc3e_pkg::ASC_HDR_LEN : plc3e_pkg::BIN_HDR_LEN;
		ecl = ascii_mode ? plc3e_pkg::ASC_EC_LEN : plc3e_pkg::BIN_EC_LEN;
		len = 16'(ecl + body.size());
		if (fk == FK_BAD_LEN)
			len = $urandom_range(1) ? 16'd0 : len ^ 16'(1 << $urandom_range(15));

		// header and end code
		if (ascii_mode) begin
			repeat (plc3e_pkg::ASC_LEN_POS) frame_bytes.push_back(8'($urandom));
			for (int k = 3; k >= 0; k--)
				frame_bytes.push_back(hex_char(len[4 * k +: 4]));
			if (fk == FK_BAD_LEN && $urandom_range(1))
				frame_bytes[plc3e_pkg::ASC_LEN_POS + $urandom_range(3)] = non_hex_char();
			if (ec == plc3e_pkg::END_CODE_OK && $urandom_range(5) == 0) begin
				// leading zero then junk still reads as a zero end code
				frame_bytes.push_back(8'h30);
				frame_bytes.push_back(non_hex_char());
				frame_bytes.push_back(hex_char(4'($urandom)));
				frame_bytes.push_back(hex_char(4'($urandom)));
			end else begin
				for (int k = 3; k >= 0; k--)
					frame_bytes.push_back(hex_char(ec[4 * k +: 4]));
			end
		end else begin
			repeat (plc3e_pkg::BIN_LEN_POS) frame_bytes.push_back(8'($urandom));
			frame_bytes.push_back(len[7:0]);
			frame_bytes.push_back(len[15:8]);
			frame_bytes.push_back(ec[7:0]);
			frame_bytes.push_back(ec[15:8]);
		end
		foreach (body[k])
			frame_bytes.push_back(body[k]);

		if (fk == FK_SHORT) begin
			n = $urandom_range(1, hdr + ecl - 1);
			while (frame_bytes.size() > n)
				void'(frame_bytes.pop_back());
		end
	endtask

	task automatic send_frame();
		foreach (frame_bytes[k])
			send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
	endtask

	task automatic run_frame(input frame_kind_t fk, input bit extreme);
		build_frame(fk, extreme);
		send_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.data_byte = '0;
		rx_ch.frame_end = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = plc3e_pkg::REG_ASCII_FORMAT;
		cfg_ch.data = '0;
		send_idle_pct = 28;
		recv_idle_pct = 86;
		sent_items = 0;
		frame_no = 0;
		ascii_mode = 1'b0;
		read_resp = 1'b1;
		bit_pts = 1'b0;
		n_bits = 16'd1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first frame in the reset setting, then random settings;
		// idle pattern swaps after one third of the bytes, no idling after two thirds
		while (sent_items < ITEM_TARGET) begin
			if (sent_items >= 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (sent_items >= ITEM_TARGET / 3) begin
				send_idle_pct = 86;
				recv_idle_pct = 28;
			end
			if (frame_no != 0 && $urandom_range(1) == 0) begin
				case ($urandom_range(4))
					0:       n_bits = 16'd1;
					1:       n_bits = 16'hFFFF;
					2:       n_bits = 16'($urandom_range(2, 24));
					3:       n_bits = 16'($urandom_range(25, 16'hFFFE));
					default: n_bits = 16'($urandom_range(1, 8));
				endcase
				set_regs(1'($urandom_range(1)), $urandom_range(4) != 0,
					1'($urandom_range(1)), n_bits);
			end
			pick = $urandom_range(99);
			if (pick < 50)
				kind = FK_GOOD;
			else if (pick < 60)
				kind = FK_BAD_LEN;
			else if (pick < 70)
				kind = FK_END_CODE;
			else if (pick < 82)
				kind = FK_BAD_DATA;
			else if (pick < 90)
				kind = FK_SHORT;
			else
				kind = FK_NOISE;
			run_frame(kind, $urandom_range(7) == 0);
			frame_no++;
		end

		settle();
		if (fail_count == 0 && pending_results == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard
	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
